[rtl/scd_pkg.sv]
// Shared types and constants for the SPI command deframer.
// No dependencies.
package scd_pkg;

  localparam int unsigned PacketLen = 16;
  localparam int unsigned CmdOffset = 0;
  localparam int unsigned PosW      = $clog2(PacketLen);
  localparam int unsigned CmdBytes  = 4;
  localparam int unsigned AddrW     = 4;

  localparam logic [7:0] SyncFirst = 8'hFA;
  localparam logic [2:0] SyncDone  = 3'd6;

  typedef enum logic [1:0] {
    RegEnable = 2'd0,
    RegStart  = 2'd1,
    RegWait   = 2'd2,
    RegRtc    = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    LedGreen = 2'd0,
    LedTurq  = 2'd1,
    LedRed   = 2'd2
  } led_e;

  typedef struct packed {
    logic ignored;
    logic packet_end;
    logic command_taken;
    logic resync;
    logic sense_on;
    logic send_on;
    led_e led_colour;
    logic clear_queue;
  } result_t;

endpackage

[rtl/spi_command_deframer_unit.sv]
// SPI command deframer: packet assembly, sync tracking and command decode.
// Depends on scd_pkg.
//
// Each accepted input byte's result is registered in the output register.
// Throughput: one byte per cycle; input ready while the output register is
// empty or being drained in the same cycle.
// Reset: asynchronous, active low; position, sync progress, flags and the
// output valid clear, registers return to enable 0 and masks 1, 2, 4.
module spi_command_deframer_unit import scd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,

  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,

  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       rx_byte_i,

  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             ignored_o,
  output logic             packet_end_o,
  output logic             command_taken_o,
  output logic             resync_o,
  output logic             sense_on_o,
  output logic             send_on_o,
  output logic [1:0]       led_colour_o,
  output logic             clear_queue_o
);

  logic        enable_q;
  logic [31:0] start_mask_q, wait_mask_q, rtc_mask_q;

  logic [PosW-1:0] pos_q, pos_d;
  logic [2:0]      sync_q, sync_d;
  logic            active_q, active_d;
  logic            sending_q, sending_d;
  logic [CmdBytes-1:0][7:0] cmd_q;
  logic [CmdBytes-1:0][7:0] cmd_now;
  logic [CmdBytes-1:0]      cmd_we;
  logic [31:0] cmd_word;

  logic    out_valid_q;
  result_t res_q, res_d;
  logic    accept, last, sync_hit, cfg_wr;
  reg_idx_e wr_idx, rd_idx;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign wr_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign rd_idx = reg_idx_e'(paddr[AddrW-1:2]);

  always_comb begin
    unique case (rd_idx)
      RegEnable: prdata = {31'd0, enable_q};
      RegStart:  prdata = start_mask_q;
      RegWait:   prdata = wait_mask_q;
      RegRtc:    prdata = rtc_mask_q;
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      start_mask_q <= 32'd1;
      wait_mask_q  <= 32'd2;
      rtc_mask_q   <= 32'd4;
    end else if (cfg_wr) begin
      unique case (wr_idx)
        RegEnable: enable_q     <= pwdata[0];
        RegStart:  start_mask_q <= pwdata;
        RegWait:   wait_mask_q  <= pwdata;
        RegRtc:    rtc_mask_q   <= pwdata;
        default:   ;
      endcase
    end
  end

  // byte path
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign last       = (pos_q == PosW'(PacketLen - 1));
  assign sync_hit   = (rx_byte_i >= SyncFirst) && (rx_byte_i == (SyncFirst + {5'd0, sync_q}));

  // command bytes; the last packet byte is taken straight from the input
  always_comb begin
    for (int k = 0; k < CmdBytes; k++) begin
      cmd_we[k]  = 1'b0;
      cmd_now[k] = 8'd0;
      if (CmdOffset + k < PacketLen) begin
        cmd_we[k] = (int'(pos_q) == CmdOffset + k);
        if (CmdOffset + k == PacketLen - 1) begin
          cmd_now[k] = rx_byte_i;
        end else begin
          cmd_now[k] = cmd_q[k];
        end
      end
    end
  end

  assign cmd_word = cmd_now;

  always_comb begin
    pos_d     = pos_q;
    sync_d    = sync_q;
    active_d  = active_q;
    sending_d = sending_q;
    res_d     = '0;
    if (!enable_q) begin
      res_d.ignored = 1'b1;
    end else begin
      sync_d = sync_hit ? sync_q + 3'd1 : 3'd0;
      pos_d  = pos_q + PosW'(1);
      if (last) begin
        res_d.packet_end = 1'b1;
        pos_d            = '0;
        if (sync_d == 3'd0 || sync_d == SyncDone) begin
          active_d            = (cmd_word & start_mask_q) != 32'd0;
          sending_d           = (cmd_word & wait_mask_q) == 32'd0;
          res_d.command_taken = 1'b1;
          res_d.clear_queue   = (cmd_word & rtc_mask_q) != 32'd0;
          sync_d              = 3'd0;
          priority if (!active_d) begin
            res_d.led_colour = LedGreen;
          end else if (sending_d) begin
            res_d.led_colour = LedTurq;
          end else begin
            res_d.led_colour = LedRed;
          end
        end
      end else if (sync_d == SyncDone) begin
        res_d.resync = 1'b1;
        sync_d       = 3'd0;
        pos_d        = '0;
      end
    end
    res_d.sense_on = active_d;
    res_d.send_on  = sending_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      sync_q      <= 3'd0;
      active_q    <= 1'b0;
      sending_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pos_q     <= pos_d;
        sync_q    <= sync_d;
        active_q  <= active_d;
        sending_q <= sending_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
      for (int k = 0; k < CmdBytes; k++) begin
        if (enable_q && cmd_we[k]) begin
          cmd_q[k] <= rx_byte_i;
        end
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ignored_o       = res_q.ignored;
  assign packet_end_o    = res_q.packet_end;
  assign command_taken_o = res_q.command_taken;
  assign resync_o        = res_q.resync;
  assign sense_on_o      = res_q.sense_on;
  assign send_on_o       = res_q.send_on;
  assign led_colour_o    = res_q.led_colour;
  assign clear_queue_o   = res_q.clear_queue;

  a_taken_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.command_taken |-> res_q.packet_end)
    else $error("command taken without packet end");

  a_end_resync_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.packet_end && res_q.resync))
    else $error("packet end and resync together");

  a_led_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.command_taken |-> res_q.led_colour == LedGreen && !res_q.clear_queue)
    else $error("led or clear without command");

  a_sync_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sync_q < SyncDone)
    else $error("sync progress out of range");

  a_accept_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("transfer lost");

endmodule
